>>> rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants and types of the bilinear Bayer demosaic core: frame
// geometry, sample width, the 3x3 window and the border flags of a pixel.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // frame geometry and sample width
  localparam int IMAGE_SIZE  = 32;
  localparam int SAMPLE_BITS = 8;

  // counter widths: the input row also counts the drain rows below the frame
  localparam int COL_W = $clog2(IMAGE_SIZE);
  localparam int ROW_W = $clog2(IMAGE_SIZE + 2);

  // line memory word: the two rows above the incoming sample
  localparam int LINE_W = 2 * SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // 3x3 neighbourhood, indexed [row][column], row 0 on top, column 2 newest
  typedef sample_t [2:0][2:0] window_t;

  // where the centre pixel lies within the frame and the Bayer pattern
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic odd_row;
    logic odd_col;
  } border_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    row_end;
    logic    frame_end;
  } pixel_t;

endpackage

>>> rtl/bbd_ram.sv
// ----------------------------------------------------------------------------
// bbd_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation of one GBRG pixel from its 3x3 window: own channel
// passed through, missing channels as truncated averages, with neighbours
// outside the frame read as zero.
// ----------------------------------------------------------------------------
module bbd_interp (
  input  bbd_pkg::window_t win,
  input  bbd_pkg::border_t bdr,
  output bbd_pkg::sample_t red,
  output bbd_pkg::sample_t green,
  output bbd_pkg::sample_t blue
);

  localparam int SW = bbd_pkg::SAMPLE_BITS;

  bbd_pkg::sample_t self_s, up_s, dn_s, lf_s, rt_s, ul_s, ur_s, dl_s, dr_s;
  logic [SW+1:0]    edge_sum, diag_sum;
  logic [SW:0]      horiz_sum, vert_sum;
  bbd_pkg::sample_t edge_avg, diag_avg, horiz_avg, vert_avg;

  // neighbours with the frame border masked to zero
  always_comb begin
    self_s = win[1][1];
    up_s   = bdr.top    ? '0 : win[0][1];
    dn_s   = bdr.bottom ? '0 : win[2][1];
    lf_s   = bdr.left   ? '0 : win[1][0];
    rt_s   = bdr.right  ? '0 : win[1][2];
    ul_s   = (bdr.top    || bdr.left)  ? '0 : win[0][0];
    ur_s   = (bdr.top    || bdr.right) ? '0 : win[0][2];
    dl_s   = (bdr.bottom || bdr.left)  ? '0 : win[2][0];
    dr_s   = (bdr.bottom || bdr.right) ? '0 : win[2][2];
  end

  // sums and truncating averages
  always_comb begin
    edge_sum  = (SW+2)'(up_s) + (SW+2)'(dn_s) + (SW+2)'(lf_s) + (SW+2)'(rt_s);
    diag_sum  = (SW+2)'(ul_s) + (SW+2)'(ur_s) + (SW+2)'(dl_s) + (SW+2)'(dr_s);
    horiz_sum = (SW+1)'(lf_s) + (SW+1)'(rt_s);
    vert_sum  = (SW+1)'(up_s) + (SW+1)'(dn_s);
    edge_avg  = edge_sum[SW+1:2];
    diag_avg  = diag_sum[SW+1:2];
    horiz_avg = horiz_sum[SW:1];
    vert_avg  = vert_sum[SW:1];
  end

  // channel selection by site type
  always_comb begin
    unique case ({bdr.odd_row, bdr.odd_col})
      2'b00: begin
        // green on a blue row
        green = self_s;
        blue  = horiz_avg;
        red   = vert_avg;
      end
      2'b11: begin
        // green on a red row
        green = self_s;
        red   = horiz_avg;
        blue  = vert_avg;
      end
      2'b01: begin
        // blue site
        blue  = self_s;
        green = edge_avg;
        red   = diag_avg;
      end
      default: begin
        // red site
        red   = self_s;
        green = edge_avg;
        blue  = diag_avg;
      end
    endcase
  end

endmodule

>>> rtl/bilinear_bayer_demosaic_core.sv
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic_core
// Bilinear demosaic of a square GBRG Bayer frame streamed in raster order,
// one raw sample per word, giving one RGB pixel per word in raster order.
// ----------------------------------------------------------------------------
// Takes one sample per clock and gives one pixel per clock while no stall
// holds the flow. A line memory of IMAGE_SIZE words, each holding the two
// rows above the incoming column, is read when a sample is taken and written
// back when that sample moves on, so every sample costs exactly one read and
// one write of that memory; a 3x3 window of registers follows it. Pixel k is
// released by sample k+IMAGE_SIZE+1 and reaches the output through the
// memory stage, the window stage and the output word. After the last sample
// of a frame the input is stalled while the last pixels drain; the next
// frame can follow straight after. No clearing after reset is needed. A
// two-word output buffer keeps the input flowing while a pixel waits.
// ----------------------------------------------------------------------------
module bilinear_bayer_demosaic_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_row_end,
  output logic                    out_frame_end
);

  localparam int N     = bbd_pkg::IMAGE_SIZE;
  localparam int COL_W = bbd_pkg::COL_W;
  localparam int ROW_W = bbd_pkg::ROW_W;
  localparam int SW    = bbd_pkg::SAMPLE_BITS;

  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(N - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(N - 1);
  localparam logic [ROW_W-1:0] ROW_DRAIN = ROW_W'(N + 1);
  localparam logic [COL_W-1:0] EROW_LAST = COL_W'(N - 1);

  // source side
  logic             flush_r, flush_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic             en, in_take, src_fire, src_emit;
  bbd_pkg::sample_t src_sample;

  // memory stage
  logic                      valid_b_r, emit_b_r;
  bbd_pkg::sample_t          samp_b_r;
  logic [COL_W-1:0]          col_b_r;
  logic [bbd_pkg::LINE_W-1:0] line_rd, line_wr;

  // window stage
  bbd_pkg::window_t win_r;
  logic             valid_c_r, emit_c_r;
  logic [COL_W-1:0] emit_row_r, emit_col_r;
  bbd_pkg::border_t bdr;
  bbd_pkg::sample_t pix_red, pix_green, pix_blue;
  bbd_pkg::pixel_t  pix;
  logic             push;

  // output buffer
  bbd_pkg::pixel_t out_r, skid_r;
  logic            out_valid_r, skid_valid_r;
  logic            take;

  // flow control: the whole pipeline moves unless the skid word is occupied
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r || flush_r;
  assign in_take  = in_valid && !in_stall;
  assign src_fire = in_take || (flush_r && en);
  assign src_sample = flush_r ? '0 : SW'(in_sample);

  // a sample releases a pixel once the window below and right of it is in
  assign src_emit = (in_row_r >= ROW_W'(2)) ||
                    ((in_row_r == ROW_W'(1)) && (in_col_r != '0));

  // input position, running on into the drain rows after the last sample
  always_comb begin
    flush_nxt  = flush_r;
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (src_fire) begin
      if (flush_r && (in_row_r == ROW_DRAIN)) begin
        flush_nxt  = 1'b0;
        in_row_nxt = '0;
        in_col_nxt = '0;
      end else if (in_col_r == COL_LAST) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
        if (in_row_r == ROW_LAST) begin
          flush_nxt = 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r  <= 1'b0;
      in_row_r <= '0;
      in_col_r <= '0;
    end else begin
      flush_r  <= flush_nxt;
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  // line memory: read the column as the sample enters, write back as it leaves the memory stage
  assign line_wr = {line_rd[SW-1:0], samp_b_r};

  bbd_ram #(
    .WIDTH (bbd_pkg::LINE_W),
    .DEPTH (N)
  ) u_line_ram (
    .clk   (clk),
    .we    (en && valid_b_r),
    .waddr (col_b_r),
    .wdata (line_wr),
    .re    (src_fire),
    .raddr (in_col_r),
    .rdata (line_rd)
  );

  // memory stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
      emit_b_r  <= 1'b0;
    end else if (en) begin
      valid_b_r <= src_fire;
      emit_b_r  <= src_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire) begin
      samp_b_r <= src_sample;
      col_b_r  <= in_col_r;
    end
  end

  // window shift: the newest column enters on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      valid_c_r <= 1'b0;
      emit_c_r  <= 1'b0;
    end else if (en) begin
      valid_c_r <= valid_b_r;
      emit_c_r  <= emit_b_r;
      if (valid_b_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= line_rd[2*SW-1:SW];
        win_r[1][2] <= line_rd[SW-1:0];
        win_r[2][2] <= samp_b_r;
      end
    end
  end

  // border flags of the centre pixel
  always_comb begin
    bdr.top     = (emit_row_r == '0);
    bdr.bottom  = (emit_row_r == EROW_LAST);
    bdr.left    = (emit_col_r == '0);
    bdr.right   = (emit_col_r == COL_LAST);
    bdr.odd_row = emit_row_r[0];
    bdr.odd_col = emit_col_r[0];
  end

  bbd_interp u_interp (
    .win   (win_r),
    .bdr   (bdr),
    .red   (pix_red),
    .green (pix_green),
    .blue  (pix_blue)
  );

  // pixel word: red, green, blue, row end, frame end
  assign pix  = {pix_red, pix_green, pix_blue, bdr.right, bdr.right && bdr.bottom};
  assign push = en && valid_c_r && emit_c_r;

  // position of the next pixel out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else if (push) begin
      if (emit_col_r == COL_LAST) begin
        emit_col_r <= '0;
        emit_row_r <= (emit_row_r == EROW_LAST) ? '0 : emit_row_r + COL_W'(1);
      end else begin
        emit_col_r <= emit_col_r + COL_W'(1);
      end
    end
  end

  // output word and skid word
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_r || take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_r <= pix;
      end else begin
        skid_r <= pix;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_r.red;
  assign out_green     = out_r.green;
  assign out_blue      = out_r.blue;
  assign out_row_end   = out_r.row_end;
  assign out_frame_end = out_r.frame_end;

endmodule
